[design/mqts_pkg.sv]
`timescale 1ns / 1ps

package mqts_pkg;

	// signed data word carried by the queue
	typedef logic signed [31:0] data_t;

	// command codes on the request channel
	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;

	// status codes on the response channel
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUSH,
		OP_POP,
		OP_POP_WB,
		OP_XFER_START,
		OP_XFER_STEP,
		OP_XFER_END
	} dp_op_t;

	// controller to datapath
	typedef struct packed {
		dp_op_t     op;
		logic       load_res;
		logic [1:0] status;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic out_empty;
		logic out_many;
		logic xfer_done;
		logic res_free;
	} dp_stat_t;

endpackage

[design/mqts_req_if.sv]
`timescale 1ns / 1ps

interface mqts_req_if;
	import mqts_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	data_t      value;

	modport source(output valid, output cmd, output value, input ready);
	modport sink(input valid, input cmd, input value, output ready);
endinterface

[design/mqts_rsp_if.sv]
`timescale 1ns / 1ps

interface mqts_rsp_if;
	import mqts_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] status;
	data_t      front_value;
	data_t      min_value;
	logic [4:0] count;

	modport source(output valid, output status, output front_value, output min_value,
		output count, input ready);
	modport sink(input valid, input status, input front_value, input min_value,
		input count, output ready);
endinterface

[design/mqts_dp.sv]
`timescale 1ns / 1ps

module mqts_dp #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mqts_pkg::dp_cmd_t  ctl,
	output mqts_pkg::dp_stat_t st,
	input  mqts_pkg::data_t    push_value,
	input  logic             res_ready,
	output logic             res_valid,
	output logic [1:0]       res_status,
	output mqts_pkg::data_t    res_front,
	output mqts_pkg::data_t    res_min,
	output logic [4:0]       res_count
);
	import mqts_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = (CW > 5) ? CW : 5;

	typedef struct packed {
		data_t val;
		data_t mn;
	} entry_t;

	function automatic data_t smin(data_t a, data_t b);
		return (a <= b) ? a : b;
	endfunction

	// enqueue stack keeps values only, its running minimum lives in a register
	data_t  in_mem [DEPTH];
	entry_t out_mem [DEPTH];

	logic [CW-1:0] in_cnt_q, out_cnt_q, rd_left_q;
	logic          rd_pend_q, res_valid_q;
	logic [AW-1:0] src_q, dst_q, pend_src_q;
	data_t         in_top_min_q, in_bot_q, run_min_q, in_rd_q;
	entry_t        out_top_q, out_rd_q;

	logic [1:0]    res_status_q;
	data_t         res_front_q, res_min_q;
	logic [4:0]    res_count_q;

	logic [CW-1:0] total;
	logic [TW-1:0] total_ext;
	data_t         push_min, xfer_min, front_c, min_c;
	logic          in_re, out_we, out_re;
	logic [AW-1:0] out_raddr;

	assign total     = in_cnt_q + out_cnt_q;
	assign total_ext = TW'(total);

	// running minimum for a push and for each transferred word
	assign push_min = (in_cnt_q == '0) ? push_value : smin(push_value, in_top_min_q);
	assign xfer_min = (dst_q == '0) ? in_rd_q : smin(in_rd_q, run_min_q);

	assign in_re     = (ctl.op == OP_XFER_STEP) && (rd_left_q != '0);
	assign out_we    = (ctl.op == OP_XFER_STEP) && rd_pend_q;
	assign out_re    = (ctl.op == OP_POP) && (out_cnt_q >= CW'(2));
	assign out_raddr = AW'(out_cnt_q - CW'(2));

	// enqueue stack memory
	always_ff @(posedge clk) begin
		if (ctl.op == OP_PUSH) begin
			in_mem[in_cnt_q[AW-1:0]] <= push_value;
		end
		if (in_re) begin
			in_rd_q <= in_mem[src_q];
		end
	end

	// dequeue stack memory
	always_ff @(posedge clk) begin
		if (out_we) begin
			out_mem[dst_q] <= '{val: in_rd_q, mn: xfer_min};
		end
		if (out_re) begin
			out_rd_q <= out_mem[out_raddr];
		end
	end

	// fill counts, transfer sequencing and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q    <= '0;
			out_cnt_q   <= '0;
			rd_left_q   <= '0;
			rd_pend_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_PUSH: in_cnt_q <= in_cnt_q + CW'(1);
				OP_POP: out_cnt_q <= out_cnt_q - CW'(1);
				OP_XFER_START: begin
					rd_left_q <= in_cnt_q;
					rd_pend_q <= 1'b0;
				end
				OP_XFER_STEP: begin
					rd_pend_q <= (rd_left_q != '0);
					if (rd_left_q != '0) begin
						rd_left_q <= rd_left_q - CW'(1);
					end
				end
				// refill done, the pop itself removes the oldest word
				OP_XFER_END: begin
					out_cnt_q <= in_cnt_q - CW'(1);
					in_cnt_q  <= '0;
				end
				default: ;
			endcase
			if (ctl.load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// cached stack tops and transfer pointers
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_PUSH: begin
				in_top_min_q <= push_min;
				if (in_cnt_q == '0) begin
					in_bot_q <= push_value;
				end
			end
			OP_POP_WB: out_top_q <= out_rd_q;
			OP_XFER_START: begin
				src_q <= AW'(in_cnt_q - CW'(1));
				dst_q <= '0;
			end
			OP_XFER_STEP: begin
				if (rd_left_q != '0) begin
					pend_src_q <= src_q;
					src_q      <= src_q - AW'(1);
				end
				if (rd_pend_q) begin
					run_min_q <= xfer_min;
					dst_q     <= dst_q + AW'(1);
					// second oldest word becomes the top once the pop completes
					if (pend_src_q == AW'(1)) begin
						out_top_q <= '{val: in_rd_q, mn: xfer_min};
					end
				end
			end
			default: ;
		endcase
	end

	// front and minimum seen after the command
	always_comb begin
		front_c = '0;
		min_c   = '0;
		if (out_cnt_q != '0) begin
			front_c = out_top_q.val;
			min_c   = (in_cnt_q != '0) ? smin(out_top_q.mn, in_top_min_q) : out_top_q.mn;
		end else if (in_cnt_q != '0) begin
			front_c = in_bot_q;
			min_c   = in_top_min_q;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.load_res) begin
			res_status_q <= ctl.status;
			res_front_q  <= front_c;
			res_min_q    <= min_c;
			res_count_q  <= total_ext[4:0];
		end
	end

	assign res_valid  = res_valid_q;
	assign res_status = res_status_q;
	assign res_front  = res_front_q;
	assign res_min    = res_min_q;
	assign res_count  = res_count_q;

	assign st.empty     = (total == '0);
	assign st.full      = (total >= CW'(DEPTH));
	assign st.out_empty = (out_cnt_q == '0);
	assign st.out_many  = (out_cnt_q >= CW'(2));
	assign st.xfer_done = !rd_pend_q && (rd_left_q == '0);
	assign st.res_free  = !res_valid_q || res_ready;

endmodule

[design/mqts_ctrl.sv]
`timescale 1ns / 1ps

module mqts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [1:0]       req_cmd,
	output logic             req_ready,
	input  mqts_pkg::dp_stat_t st,
	output mqts_pkg::dp_cmd_t  ctl
);
	import mqts_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_POP_WB = 2'd1;
	localparam logic [1:0] S_XFER   = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	logic [1:0] state_q, state_d;
	logic [1:0] status_q, status_d;

	assign req_ready = (state_q == S_IDLE);

	// next state and datapath command
	always_comb begin
		ctl      = '{op: OP_NONE, load_res: 1'b0, status: ST_OK};
		state_d  = state_q;
		status_d = status_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d  = S_DONE;
					status_d = ST_OK;
					if (req_cmd == CMD_PUSH) begin
						if (st.full) begin
							status_d = ST_FULL;
						end else begin
							ctl.op = OP_PUSH;
						end
					end else if (st.empty) begin
						status_d = ST_EMPTY;
					end else if (req_cmd == CMD_POP) begin
						if (st.out_empty) begin
							ctl.op  = OP_XFER_START;
							state_d = S_XFER;
						end else begin
							ctl.op = OP_POP;
							if (st.out_many) begin
								state_d = S_POP_WB;
							end
						end
					end
				end
			end
			S_POP_WB: begin
				ctl.op  = OP_POP_WB;
				state_d = S_DONE;
			end
			S_XFER: begin
				if (st.xfer_done) begin
					ctl.op  = OP_XFER_END;
					state_d = S_DONE;
				end else begin
					ctl.op = OP_XFER_STEP;
				end
			end
			S_DONE: begin
				ctl.status = status_q;
				if (st.res_free) begin
					ctl.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

[design/min_queue_two_stacks_top.sv]
// FIFO of signed 32-bit words that also reports its minimum, built from an enqueue stack
// and a dequeue stack held in single-port-read memories of DEPTH entries. Each request word
// (push, pop or peek) yields one response word with status, front, minimum and count after
// the command. Push, peek and any rejected command go from acceptance to S_DONE, which
// loads the response register once the response slot is free; a pop with two or more words
// in the dequeue stack also passes S_POP_WB, which takes in the registered memory read of
// the new top. A pop that finds the dequeue stack empty first moves the whole enqueue
// stack over, one word per cycle through the memory read and write ports. Each word moves
// over once. A new request is accepted only after the response to the last one has been
// loaded. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module min_queue_two_stacks_top #(
	parameter int DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	mqts_req_if.sink   req,
	mqts_rsp_if.source rsp
);
	import mqts_pkg::*;

	localparam logic [4:0] FULL_CNT = 5'(DEPTH);

	dp_cmd_t  ctl;
	dp_stat_t st;

	mqts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.st        (st),
		.ctl       (ctl)
	);

	mqts_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.st         (st),
		.push_value (req.value),
		.res_ready  (rsp.ready),
		.res_valid  (rsp.valid),
		.res_status (rsp.status),
		.res_front  (rsp.front_value),
		.res_min    (rsp.min_value),
		.res_count  (rsp.count)
	);

	// one word at a time: no back-to-back acceptance
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted in consecutive cycles");

	// an empty status only comes with an empty queue
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_EMPTY) |-> (rsp.count == 5'd0))
		else $error("empty status with nonzero count");

	// a full status only comes with a full queue
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_FULL) |-> (rsp.count == FULL_CNT))
		else $error("full status with queue not full");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
	import mqts_pkg::*;

	localparam int DEPTH = 16;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;
	// code 3 is not named by the package; the block treats it as a peek
	localparam logic [1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		data_t      value;
		logic       pause_first;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0] status;
		data_t      front_value;
		data_t      min_value;
		logic [4:0] count;
	} rsp_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mqts_req_if req_if();
	mqts_rsp_if rsp_if();

	min_queue_two_stacks_top #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #4 clk = ~clk;

	cmd_word_t cmd_q[$];
	rsp_word_t rsp_exp_q[$];
	cmd_word_t nxt_word;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_cnt = 0;
	int idle_cycles = 0;

	// shadow copy of both stacks
	data_t enq_vals[DEPTH];
	data_t enq_mins[DEPTH];
	data_t deq_vals[DEPTH];
	data_t deq_mins[DEPTH];
	int enq_cnt = 0;
	int deq_cnt = 0;

	function automatic data_t smaller(input data_t a, input data_t b);
		return (a <= b) ? a : b;
	endfunction

	// update the shadow queue for one command and record the response word it yields
	task automatic apply_cmd(input logic [1:0] op, input data_t val);
		rsp_word_t r;
		int total;
		int k;
		r.status = ST_OK;
		r.front_value = '0;
		r.min_value = '0;
		total = enq_cnt + deq_cnt;
		if (op == CMD_PUSH) begin
			if (total >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				enq_vals[enq_cnt] = val;
				if (enq_cnt == 0) begin
					enq_mins[enq_cnt] = val;
				end else begin
					enq_mins[enq_cnt] = smaller(val, enq_mins[enq_cnt - 1]);
				end
				enq_cnt++;
			end
		end else if (total == 0) begin
			r.status = ST_EMPTY;
		end else if (op == CMD_POP) begin
			// refill the dequeue stack in reverse order
			if (deq_cnt == 0) begin
				for (k = 0; k < enq_cnt; k++) begin
					deq_vals[k] = enq_vals[enq_cnt - 1 - k];
					if (k == 0) begin
						deq_mins[k] = deq_vals[k];
					end else begin
						deq_mins[k] = smaller(deq_vals[k], deq_mins[k - 1]);
					end
				end
				deq_cnt = enq_cnt;
				enq_cnt = 0;
			end
			deq_cnt--;
		end
		total = enq_cnt + deq_cnt;
		if (total > 0) begin
			if (deq_cnt > 0) begin
				r.front_value = deq_vals[deq_cnt - 1];
				r.min_value = deq_mins[deq_cnt - 1];
				if (enq_cnt > 0) begin
					r.min_value = smaller(r.min_value, enq_mins[enq_cnt - 1]);
				end
			end else begin
				r.front_value = enq_vals[0];
				r.min_value = enq_mins[enq_cnt - 1];
			end
		end
		r.count = total[4:0];
		rsp_exp_q.push_back(r);
	endtask

	task automatic check_word(input rsp_word_t e);
		if (rsp_if.status !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, rsp_if.status);
			err_cnt++;
		end
		if (rsp_if.front_value !== e.front_value) begin
			$error("front_value: expected %0d, got %0d", e.front_value, rsp_if.front_value);
			err_cnt++;
		end
		if (rsp_if.min_value !== e.min_value) begin
			$error("min_value: expected %0d, got %0d", e.min_value, rsp_if.min_value);
			err_cnt++;
		end
		if (rsp_if.count !== e.count) begin
			$error("count: expected %0d, got %0d", e.count, rsp_if.count);
			err_cnt++;
		end
	endtask

	task automatic add_word(input logic [1:0] op, input data_t val, input logic pause);
		cmd_word_t w;
		w.cmd = op;
		w.value = val;
		w.pause_first = pause;
		cmd_q.push_back(w);
	endtask

	task automatic wait_drained();
		while (cmd_q.size() != 0 || req_if.valid || rsp_exp_q.size() != 0)
			@(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.cmd <= CMD_PUSH;
			req_if.value <= '0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				apply_cmd(req_if.cmd, req_if.value);
			end
			if (!req_if.valid || req_if.ready) begin
				if (cmd_q.size() == 0 || (cmd_q[0].pause_first && rsp_exp_q.size() != 0) ||
						$urandom_range(99) < send_idle_pct) begin
					req_if.valid <= 1'b0;
				end else begin
					nxt_word = cmd_q.pop_front();
					req_if.valid <= 1'b1;
					req_if.cmd <= nxt_word.cmd;
					req_if.value <= nxt_word.value;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (rsp_exp_q.size() == 0) begin
					$error("response word with no command pending");
					err_cnt++;
				end else begin
					check_word(rsp_exp_q.pop_front());
				end
			end
			rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int i;
		int ph;
		int r;
		int shadow;
		bit filling;
		logic [1:0] op;
		data_t v;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty queue, extremes, spare code, fill to full, refill with a new minimum
		add_word(CMD_PEEK, 32'sd0, 1'b0);
		add_word(CMD_PUSH, 32'sh7fffffff, 1'b0);
		add_word(CMD_PUSH, 32'sh80000000, 1'b0);
		add_word(CMD_SPARE, 32'shffffffff, 1'b0);
		add_word(CMD_POP, 32'sd0, 1'b0);
		add_word(CMD_POP, 32'sd0, 1'b0);
		add_word(CMD_POP, 32'sh55555555, 1'b0);
		for (i = 0; i < DEPTH; i++)
			add_word(CMD_PUSH, (i % 2) ? -i : i, 1'b0);
		add_word(CMD_PUSH, 32'sh7fffffff, 1'b0);
		add_word(CMD_POP, 32'sd0, 1'b0);
		add_word(CMD_PUSH, 32'sh80000000, 1'b0);
		wait_drained();

		// random walks that fill and drain the queue under each idling mix
		shadow = 0;
		filling = 1'b1;
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 54;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 54;
				end
				default: begin
					send_idle_pct = 28;
					recv_stall_pct = 28;
				end
			endcase
			for (i = 0; i < 100; i++) begin
				if (shadow == 0)
					filling = 1'b1;
				else if (shadow == DEPTH && $urandom_range(1) == 0)
					filling = 1'b0;
				else if ($urandom_range(19) == 0)
					filling = ~filling;
				r = $urandom_range(99);
				if (filling)
					op = (r < 70) ? CMD_PUSH : (r < 88) ? CMD_POP : (r < 96) ? CMD_PEEK : CMD_SPARE;
				else
					op = (r < 20) ? CMD_PUSH : (r < 85) ? CMD_POP : (r < 96) ? CMD_PEEK : CMD_SPARE;
				case ($urandom_range(9))
					0: v = 32'sh80000000;
					1: v = 32'sh7fffffff;
					2, 3: v = int'($urandom_range(8)) - 4;
					default: v = $urandom;
				endcase
				if (op == CMD_PUSH && shadow < DEPTH)
					shadow++;
				else if (op == CMD_POP && shadow > 0)
					shadow--;
				add_word(op, v, (ph == 2 && i == 50));
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
